// ----- rtl/rqr6_pkg.sv -----
package rqr6_pkg;

   // Field widths fixed by the interface.
   localparam int QuatWidth   = 16;
   localparam int RotWidth    = 16;
   // Reduced product components hold magnitudes below 2^30.
   localparam int RedWidth    = 31;
   // Numerators, norm and partial remainders.
   localparam int WideWidth   = 64;
   // Quotient register, wide enough for the largest fraction setting.
   localparam int QuotWidth   = 31;
   localparam int Lanes       = 6;
   localparam int FracBitsDef = 14;

   // One input word: base and anchor quaternions.
   typedef struct packed {
      logic signed [QuatWidth-1:0] base_w;
      logic signed [QuatWidth-1:0] base_x;
      logic signed [QuatWidth-1:0] base_y;
      logic signed [QuatWidth-1:0] base_z;
      logic signed [QuatWidth-1:0] anchor_w;
      logic signed [QuatWidth-1:0] anchor_x;
      logic signed [QuatWidth-1:0] anchor_y;
      logic signed [QuatWidth-1:0] anchor_z;
   } req_type;

   // One result word: first two matrix columns, row by row.
   typedef struct packed {
      logic signed [RotWidth-1:0] rot_00;
      logic signed [RotWidth-1:0] rot_01;
      logic signed [RotWidth-1:0] rot_10;
      logic signed [RotWidth-1:0] rot_11;
      logic signed [RotWidth-1:0] rot_20;
      logic signed [RotWidth-1:0] rot_21;
   } rsp_type;

   // Relative quaternion after range reduction.
   typedef struct packed {
      logic signed [RedWidth-1:0] r;
      logic signed [RedWidth-1:0] i;
      logic signed [RedWidth-1:0] j;
      logic signed [RedWidth-1:0] k;
   } quat_type;

   // State carried through the division pipeline.
   typedef struct packed {
      logic [WideWidth-1:0]                 den;
      logic [Lanes-1:0][WideWidth-1:0]      rem;
      logic [Lanes-1:0][QuotWidth-1:0]      quot;
      logic [Lanes-1:0]                     neg;
      logic [Lanes-1:0]                     sat;
      logic                                 zero;
   } div_word_type;

endpackage

// ----- rtl/rqr6_prod.sv -----
module rqr6_prod (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rqr6_pkg::req_type     in_word,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rqr6_pkg::quat_type    out_word
);

   logic signed [15:0] bq [4];
   logic signed [15:0] aq [4];
   logic signed [31:0] p_in [4][4];
   logic signed [31:0] p_ff [4][4];
   logic signed [33:0] c_in [4];
   logic signed [33:0] c_ff [4];
   logic [33:0]        m [4];
   logic [33:0]        m_or;
   logic [1:0]         shift;
   logic [33:0]        red [4];
   logic signed [30:0] q_val [4];
   rqr6_pkg::quat_type q_in;
   rqr6_pkg::quat_type q_ff;
   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   function automatic logic signed [33:0] sx(input logic signed [31:0] v);
      sx = {{2{v[31]}}, v};
   endfunction

   // Stage enables: a stage moves when it is empty or its successor moves.
   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   assign bq[0] = in_word.base_w;
   assign bq[1] = in_word.base_x;
   assign bq[2] = in_word.base_y;
   assign bq[3] = in_word.base_z;
   assign aq[0] = in_word.anchor_w;
   assign aq[1] = in_word.anchor_x;
   assign aq[2] = in_word.anchor_y;
   assign aq[3] = in_word.anchor_z;

   // All sixteen component products of base and anchor.
   always_comb begin
      for (int a = 0; a < 4; a++) begin
         for (int b = 0; b < 4; b++) begin
            p_in[a][b] = bq[a] * aq[b];
         end
      end
   end

   // Conjugate of base times anchor.
   always_comb begin
      c_in[0] = sx(p_ff[0][0]) + sx(p_ff[1][1]) + sx(p_ff[2][2]) + sx(p_ff[3][3]);
      c_in[1] = sx(p_ff[0][1]) - sx(p_ff[1][0]) - sx(p_ff[2][3]) + sx(p_ff[3][2]);
      c_in[2] = sx(p_ff[0][2]) + sx(p_ff[1][3]) - sx(p_ff[2][0]) - sx(p_ff[3][1]);
      c_in[3] = sx(p_ff[0][3]) - sx(p_ff[1][2]) + sx(p_ff[2][1]) - sx(p_ff[3][0]);
   end

   // Common right shift that brings every magnitude below 2^30.
   always_comb begin
      m_or = '0;
      for (int t = 0; t < 4; t++) begin
         m[t] = c_ff[t][33] ? 34'(-c_ff[t]) : 34'(c_ff[t]);
         m_or = m_or | m[t];
      end
      priority if (m_or[32]) begin
         shift = 2'd3;
      end else if (m_or[31]) begin
         shift = 2'd2;
      end else if (m_or[30]) begin
         shift = 2'd1;
      end else begin
         shift = 2'd0;
      end
      for (int t = 0; t < 4; t++) begin
         red[t]   = m[t] >> shift;
         q_val[t] = c_ff[t][33] ? -$signed({1'b0, red[t][29:0]})
                                :  $signed({1'b0, red[t][29:0]});
      end
      q_in.r = q_val[0];
      q_in.i = q_val[1];
      q_in.j = q_val[2];
      q_in.k = q_val[3];
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (en1 && in_valid) p_ff <= p_in;
      if (en2 && v1_ff) c_ff <= c_in;
      if (en3 && v2_ff) q_ff <= q_in;
   end

   assign out_valid = v3_ff;
   assign out_word  = q_ff;

endmodule

// ----- rtl/rqr6_square.sv -----
module rqr6_square (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  rqr6_pkg::quat_type       in_word,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rqr6_pkg::div_word_type   out_word
);

   logic signed [61:0] rr_ff, ii_ff, jj_ff, kk_ff, ij_ff, kr_ff, ik_ff, jr_ff, jk_ff, ir_ff;
   logic signed [63:0] n_in [6];
   logic signed [63:0] n_ff [6];
   logic [63:0]        den_in, den_ff, den3_ff;
   logic [63:0]        mag_in [6];
   logic [63:0]        mag_ff [6];
   logic [5:0]         neg_ff;
   logic               zero_ff;
   rqr6_pkg::div_word_type dw_in, dw_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   function automatic logic signed [63:0] sx(input logic signed [61:0] v);
      sx = {{2{v[61]}}, v};
   endfunction

   // Stage enables.
   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // Norm and matrix numerators.
   always_comb begin
      den_in  = 64'(sx(rr_ff) + sx(ii_ff) + sx(jj_ff) + sx(kk_ff));
      n_in[0] = sx(rr_ff) + sx(ii_ff) - sx(jj_ff) - sx(kk_ff);
      n_in[1] = (sx(ij_ff) - sx(kr_ff)) <<< 1;
      n_in[2] = (sx(ij_ff) + sx(kr_ff)) <<< 1;
      n_in[3] = sx(rr_ff) - sx(ii_ff) + sx(jj_ff) - sx(kk_ff);
      n_in[4] = (sx(ik_ff) - sx(jr_ff)) <<< 1;
      n_in[5] = (sx(jk_ff) + sx(ir_ff)) <<< 1;
   end

   // Numerator magnitudes.
   always_comb begin
      for (int l = 0; l < 6; l++) begin
         mag_in[l] = n_ff[l][63] ? 64'(-n_ff[l]) : 64'(n_ff[l]);
      end
   end

   // Saturation check and division set-up.
   always_comb begin
      dw_in.den  = den3_ff;
      dw_in.neg  = neg_ff;
      dw_in.zero = zero_ff;
      for (int l = 0; l < 6; l++) begin
         dw_in.rem[l]  = mag_ff[l];
         dw_in.quot[l] = '0;
         dw_in.sat[l]  = mag_ff[l] >= den3_ff;
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         rr_ff <= in_word.r * in_word.r;
         ii_ff <= in_word.i * in_word.i;
         jj_ff <= in_word.j * in_word.j;
         kk_ff <= in_word.k * in_word.k;
         ij_ff <= in_word.i * in_word.j;
         kr_ff <= in_word.k * in_word.r;
         ik_ff <= in_word.i * in_word.k;
         jr_ff <= in_word.j * in_word.r;
         jk_ff <= in_word.j * in_word.k;
         ir_ff <= in_word.i * in_word.r;
      end
      if (en2 && v1_ff) begin
         n_ff   <= n_in;
         den_ff <= den_in;
      end
      if (en3 && v2_ff) begin
         mag_ff  <= mag_in;
         den3_ff <= den_ff;
         zero_ff <= den_ff == '0;
         for (int l = 0; l < 6; l++) begin
            neg_ff[l] <= n_ff[l][63];
         end
      end
      if (en4 && v3_ff) dw_ff <= dw_in;
   end

   assign out_valid = v4_ff;
   assign out_word  = dw_ff;

endmodule

// ----- rtl/rqr6_div_step.sv -----
module rqr6_div_step (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  rqr6_pkg::div_word_type   in_word,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rqr6_pkg::div_word_type   out_word
);

   rqr6_pkg::div_word_type dw_in, dw_ff;
   logic [63:0] rem2;
   logic        v_ff;
   logic        en;

   assign en       = !v_ff || out_ready;
   assign in_ready = en;

   // One restoring division step on each of the six lanes.
   always_comb begin
      dw_in = in_word;
      for (int l = 0; l < 6; l++) begin
         rem2 = in_word.rem[l] << 1;
         if (rem2 >= in_word.den) begin
            dw_in.rem[l]  = rem2 - in_word.den;
            dw_in.quot[l] = {in_word.quot[l][rqr6_pkg::QuotWidth-2:0], 1'b1};
         end else begin
            dw_in.rem[l]  = rem2;
            dw_in.quot[l] = {in_word.quot[l][rqr6_pkg::QuotWidth-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) dw_ff <= dw_in;
   end

   assign out_valid = v_ff;
   assign out_word  = dw_ff;

endmodule

// ----- rtl/rqr6_round.sv -----
module rqr6_round #(
   parameter int FRAC_BITS = rqr6_pkg::FracBitsDef
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  rqr6_pkg::div_word_type   in_word,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rqr6_pkg::rsp_type        out_word
);

   localparam logic [31:0] One = 32'd1 << FRAC_BITS;

   logic [FRAC_BITS+1:0] q_inc;
   logic [31:0]          q_rnd;
   logic [31:0]          mag;
   logic signed [15:0]   lane_val [6];
   logic signed [15:0]   id_one;
   rqr6_pkg::rsp_type    rsp_in, rsp_ff;
   logic                 v_ff;
   logic                 en;

   assign en       = !v_ff || out_ready;
   assign in_ready = en;

   // Round half away from zero, limit to one, apply the sign, clip to 16 bits.
   always_comb begin
      for (int l = 0; l < 6; l++) begin
         q_inc = {1'b0, in_word.quot[l][FRAC_BITS:0]} + 1'b1;
         q_rnd = 32'(q_inc[FRAC_BITS+1:1]);
         mag   = (in_word.sat[l] || q_rnd > One) ? One : q_rnd;
         if (in_word.neg[l]) begin
            lane_val[l] = (mag > 32'd32768) ? -16'sd32768 : 16'(-mag);
         end else begin
            lane_val[l] = (mag > 32'd32767) ? 16'sd32767 : 16'(mag);
         end
      end
      id_one = (One > 32'd32767) ? 16'sd32767 : 16'(One);
      if (in_word.zero) begin
         rsp_in.rot_00 = id_one;
         rsp_in.rot_01 = '0;
         rsp_in.rot_10 = '0;
         rsp_in.rot_11 = id_one;
         rsp_in.rot_20 = '0;
         rsp_in.rot_21 = '0;
      end else begin
         rsp_in.rot_00 = lane_val[0];
         rsp_in.rot_01 = lane_val[1];
         rsp_in.rot_10 = lane_val[2];
         rsp_in.rot_11 = lane_val[3];
         rsp_in.rot_20 = lane_val[4];
         rsp_in.rot_21 = lane_val[5];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) rsp_ff <= rsp_in;
   end

   assign out_valid = v_ff;
   assign out_word  = rsp_ff;

endmodule

// ----- rtl/relative_quaternion_to_rot6d_unit.sv -----
// Throughput: one word per cycle while rsp_ready is high; the depth is set by the
// restoring divider, one quotient bit per stage over FRAC_BITS + 1 stages, shared
// by six lanes. Every stage has its own valid bit and moves whenever its successor
// has room. Synchronous reset clears all valid bits; payload registers are not
// reset.
module relative_quaternion_to_rot6d_unit #(
   parameter int FRAC_BITS = rqr6_pkg::FracBitsDef
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rqr6_pkg::req_type    req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rqr6_pkg::rsp_type    rsp_word
);

   localparam int Steps = FRAC_BITS + 1;

   logic                   qv, qr;
   rqr6_pkg::quat_type     qw;
   logic [Steps:0]         dv, dr;
   rqr6_pkg::div_word_type dw [Steps+1];

   // Quaternion product and range reduction.
   rqr6_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_word   (req_word),
      .out_valid (qv),
      .out_ready (qr),
      .out_word  (qw)
   );

   // Squares, norm, numerators and divider set-up.
   rqr6_square u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (qv),
      .in_ready  (qr),
      .in_word   (qw),
      .out_valid (dv[0]),
      .out_ready (dr[0]),
      .out_word  (dw[0])
   );

   // Divider chain, one quotient bit per stage.
   for (genvar s = 0; s < Steps; s++) begin : g_div
      rqr6_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv[s]),
         .in_ready  (dr[s]),
         .in_word   (dw[s]),
         .out_valid (dv[s+1]),
         .out_ready (dr[s+1]),
         .out_word  (dw[s+1])
      );
   end

   // Rounding, saturation and output register.
   rqr6_round #(
      .FRAC_BITS (FRAC_BITS)
   ) u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv[Steps]),
      .in_ready  (dr[Steps]),
      .in_word   (dw[Steps]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (rsp_word)
   );

endmodule
